FILE: hw/rtl/sync_framed_command_receiver_crc16_top_defines.svh
// Assertion macros for the framed command receiver.
// Both macros sample on i_clk and are quiet while i_rst_n is low.
`ifndef SYNC_FRAMED_COMMAND_RECEIVER_CRC16_TOP_DEFINES_SVH
`define SYNC_FRAMED_COMMAND_RECEIVER_CRC16_TOP_DEFINES_SVH

`ifndef SYNTH
// Free-form property, may use |-> or |=>
`define SFCR_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define SFCR_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SFCR_CHECK(label, prop, msg)
`define SFCR_IMPLY(label, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/sfcr_pkg.sv
package sfcr_pkg;

    // Sync pair and CRC-16 generator (0x8005, MSB first, init 0)
    localparam logic [7:0]  SYNC_FIRST  = 8'hFF;
    localparam logic [7:0]  SYNC_SECOND = 8'hA5;
    localparam logic [15:0] CRC_POLY    = 16'h8005;

    // Default frame length in bytes, sync pair included
    localparam int FRAME_BYTES_DEF = 16;

    // Frame byte positions of the command fields
    localparam int POS_MODE     = 3;
    localparam int POS_FAN_HI   = 4;
    localparam int POS_FAN_LO   = 7;
    localparam int POS_STEP_EN  = 8;
    localparam int POS_GEAR     = 9;
    localparam int POS_DIR      = 10;
    localparam int POS_FREQ_HI  = 12;
    localparam int POS_FREQ_LO  = 13;

    // Byte offset of the first frame byte after the sync pair
    localparam int POS_BODY     = 2;

    // One byte step of the CRC, eight shift/xor steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/sync_framed_command_receiver_crc16_top.sv
// Framed command receiver: takes one received serial byte per beat, locks on the sync
// pair 0xFF 0xA5, runs CRC-16 (poly 0x8005, init 0, MSB first) over the whole frame of
// FRAME_BYTES bytes and, on the frame's last byte, delivers one result beat. A zero
// residue updates the held command (fields forced to zero when the mode byte's enable
// bit, chosen by the configuration register, is clear) and sets o_frame_ok; a bad CRC
// repeats the held command with o_frame_ok low. Other bytes produce no result. A byte
// is taken every cycle unless the input stalls: each byte passes an input register,
// one CRC byte step plus field capture, and lands in the result/state registers.
// Input stalls only while an untaken result blocks a byte waiting in the input
// register.
`include "sync_framed_command_receiver_crc16_top_defines.svh"

module sync_framed_command_receiver_crc16_top
    import sfcr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_ok,
    output logic [7:0]  o_mode_byte,
    output logic [31:0] o_fan_demand_bits,
    output logic [7:0]  o_stepper_enable,
    output logic [7:0]  o_stepper_gear,
    output logic [7:0]  o_stepper_direction,
    output logic [15:0] o_stepper_freq_demand
);

    localparam int PW = $clog2(FRAME_BYTES);
    localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        COLLECT
    } t_phase;

    // control state
    t_phase         r_phase, n_phase;
    logic [PW-1:0]  r_pos, n_pos;
    logic [15:0]    r_crc, n_crc;
    logic [2:0]     r_en_pos;
    logic           r_in_vld;
    logic [7:0]     r_in_byte;
    logic           r_out_vld;
    logic           r_out_ok;

    // captured frame bytes
    logic [7:0]     r_cap_mode;
    logic [31:0]    r_cap_fan;
    logic [7:0]     r_cap_en;
    logic [7:0]     r_cap_gear;
    logic [7:0]     r_cap_dir;
    logic [15:0]    r_cap_freq;

    // held command, drives the result fields
    logic [7:0]     r_hold_mode;
    logic [31:0]    r_hold_fan;
    logic [7:0]     r_hold_en;
    logic [7:0]     r_hold_gear;
    logic [7:0]     r_hold_dir;
    logic [15:0]    r_hold_freq;

    logic           w_out_free;
    logic           w_proc;
    logic           w_emit;
    logic           w_crc_ok;
    logic           w_en_bit;
    logic [15:0]    w_crc_step;

    // handshake: result slot frees when empty or taken
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_proc     = r_in_vld && w_out_free;
    assign o_stall    = r_in_vld && !w_out_free;

    // per-byte CRC step; r_crc is zero while hunting the first sync byte
    assign w_crc_step = crc16_byte(r_crc, r_in_byte);
    assign w_crc_ok   = (w_crc_step == 16'h0000);
    assign w_emit     = w_proc && (r_phase == COLLECT) && (r_pos == LAST_POS);
    assign w_en_bit   = r_cap_mode[r_en_pos];

    // sync hunt and frame position
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_crc   = r_crc;
        case (r_phase)
            COLLECT: begin
                if (r_pos == LAST_POS) begin
                    n_phase = HUNT_FIRST;
                    n_pos   = '0;
                    n_crc   = '0;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_crc   = w_crc_step;
                end
            end
            HUNT_SECOND: begin
                if (r_in_byte == SYNC_SECOND) begin
                    n_phase = COLLECT;
                    n_pos   = PW'(POS_BODY);
                    n_crc   = w_crc_step;
                end else begin
                    n_phase = HUNT_FIRST;
                    n_pos   = '0;
                    n_crc   = '0;
                end
            end
            default: begin
                if (r_in_byte == SYNC_FIRST) begin
                    n_phase = HUNT_SECOND;
                    n_pos   = PW'(1);
                    n_crc   = w_crc_step;
                end else begin
                    n_phase = HUNT_FIRST;
                    n_pos   = '0;
                    n_crc   = '0;
                end
            end
        endcase
    end

    // state, input register and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= HUNT_FIRST;
            r_pos       <= '0;
            r_crc       <= '0;
            r_en_pos    <= '0;
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_out_ok    <= 1'b0;
            r_hold_mode <= '0;
            r_hold_fan  <= '0;
            r_hold_en   <= '0;
            r_hold_gear <= '0;
            r_hold_dir  <= '0;
            r_hold_freq <= '0;
        end else begin
            if (i_cfg_we) begin
                r_en_pos <= i_cfg_wdata;
            end
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (w_proc) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_crc   <= n_crc;
            end
            if (w_out_free) begin
                r_out_vld <= w_emit;
            end
            if (w_emit) begin
                r_out_ok <= w_crc_ok;
            end
            // good frame updates the held command
            if (w_emit && w_crc_ok) begin
                r_hold_mode <= r_cap_mode;
                r_hold_fan  <= w_en_bit ? r_cap_fan  : '0;
                r_hold_en   <= w_en_bit ? r_cap_en   : '0;
                r_hold_gear <= w_en_bit ? r_cap_gear : '0;
                r_hold_dir  <= w_en_bit ? r_cap_dir  : '0;
                r_hold_freq <= w_en_bit ? r_cap_freq : '0;
            end
        end
    end

    // input byte register
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // field capture; multi-byte fields shift in MSB first
    always_ff @(posedge i_clk) begin
        if (w_proc && r_phase == COLLECT) begin
            if (r_pos == PW'(POS_MODE)) begin
                r_cap_mode <= r_in_byte;
            end
            if (r_pos >= PW'(POS_FAN_HI) && r_pos <= PW'(POS_FAN_LO)) begin
                r_cap_fan <= {r_cap_fan[23:0], r_in_byte};
            end
            if (r_pos == PW'(POS_STEP_EN)) begin
                r_cap_en <= r_in_byte;
            end
            if (r_pos == PW'(POS_GEAR)) begin
                r_cap_gear <= r_in_byte;
            end
            if (r_pos == PW'(POS_DIR)) begin
                r_cap_dir <= r_in_byte;
            end
            if (r_pos == PW'(POS_FREQ_HI) || r_pos == PW'(POS_FREQ_LO)) begin
                r_cap_freq <= {r_cap_freq[7:0], r_in_byte};
            end
        end
    end

    assign o_valid               = r_out_vld;
    assign o_frame_ok            = r_out_ok;
    assign o_mode_byte           = r_hold_mode;
    assign o_fan_demand_bits     = r_hold_fan;
    assign o_stepper_enable      = r_hold_en;
    assign o_stepper_gear        = r_hold_gear;
    assign o_stepper_direction   = r_hold_dir;
    assign o_stepper_freq_demand = r_hold_freq;

    // checks
    `SFCR_IMPLY(a_new_result_at_frame_end, o_valid && !$past(o_valid && i_stall), $past(w_emit), "result beat without a frame end")
    `SFCR_CHECK(a_hold_only_on_good_frame, !(w_emit && w_crc_ok) |=> $stable(r_hold_mode) && $stable(r_hold_fan) && $stable(r_hold_freq), "held command changed without a good frame")
    `SFCR_CHECK(a_disabled_fields_zero, w_emit && w_crc_ok && !w_en_bit |=> o_fan_demand_bits == '0 && o_stepper_freq_demand == '0 && o_stepper_gear == '0, "disabled frame left nonzero fields")
    `SFCR_IMPLY(a_pos_in_frame, r_phase == COLLECT, r_pos >= PW'(POS_BODY) && r_pos <= LAST_POS, "frame position out of range")
    `SFCR_IMPLY(a_crc_clear_hunting, r_phase == HUNT_FIRST, r_crc == 16'h0000 && r_pos == '0, "CRC or position not cleared while hunting")

endmodule
